/* design/psfl_pkg.sv */
package psfl_pkg;

  // Default geometry of the store
  localparam int MAX_PAGES_DEF = 64;
  localparam int MAX_SLOTS_DEF = 64;

  // Field widths fixed by the interface
  localparam int SPP_W    = 7;
  localparam int PAGE_W   = 6;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;

  localparam logic [SPP_W-1:0] SPP_RESET = 7'd16;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAGE_RANGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SLOT_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SLOT_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

  typedef struct packed {
    logic              op;
    logic [PAGE_W-1:0] page_index;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   granted_page;
    logic [SLOT_W-1:0]   granted_slot;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch request, issue first reads
    logic make;       // chain one slot of a new page
    logic rd_page;    // read page list heads of the latched page
    logic eval;       // decide free / first allocate step
    logic pop;        // finish allocate pop
    logic full_emit;  // answer store full at once
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic req_free;
    logic op_free;
    logic head_valid;
    logic store_full;
    logic make_last;
    logic slot_bad;
  } stat_t;

endpackage

/* design/page_slot_free_list_allocator_top.sv */
// Steps: a free is loaded, then evaluated; an allocate is loaded, evaluated, popped, and
//   if it opens a new page it first chains n slots, n being slots_per_page clamped to
//   1..MAX_SLOTS (one slot chained a cycle). Store full, no not-full page: answered at load.
// Throughput: one item at a time; the next transfer is taken in the cycle done shows.
// The receiver cannot stall: each result is marked by done, high for exactly one cycle.
// Reset (rst, synchronous): no pages, empty not-full list, slots_per_page back to 16.
module page_slot_free_list_allocator_top #(
  parameter int MAX_PAGES = psfl_pkg::MAX_PAGES_DEF,
  parameter int MAX_SLOTS = psfl_pkg::MAX_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  psfl_pkg::req_t             req,
  output logic                       done,
  output psfl_pkg::rsp_t             rsp,
  input  logic                       cfg_we,
  input  logic [psfl_pkg::SPP_W-1:0] cfg_wdata
);

  psfl_pkg::ctrl_t cmd;
  psfl_pkg::stat_t stat;

  // Sequencer: accept, chain a new page slot by slot, then read-modify-write the lists
  psfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Page and slot list memories, head of the not-full list, result register
  psfl_dp #(
    .MAX_PAGES (MAX_PAGES),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .rsp       (rsp)
  );

`ifndef ASSERT_OFF
  // A free always answers on time: load, then eval, then the registered done
  a_free_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.op == psfl_pkg::OP_FREE) |-> ##2 done)
    else $error("free result not delivered on time");

  // The block is back to idle whenever a result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  // A failed request grants nothing
  a_no_grant_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != psfl_pkg::ST_OK) |->
      (rsp.granted_page == '0 && rsp.granted_slot == '0))
    else $error("grant on failed request");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == psfl_pkg::ST_OK || rsp.status == psfl_pkg::ST_PAGE_RANGE ||
              rsp.status == psfl_pkg::ST_SLOT_RANGE || rsp.status == psfl_pkg::ST_SLOT_EMPTY ||
              rsp.status == psfl_pkg::ST_FULL))
    else $error("undefined status code");
`endif

endmodule

/* design/psfl_ctrl.sv */
module psfl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  psfl_pkg::stat_t   stat,
  output psfl_pkg::ctrl_t   cmd,
  output logic              busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAKE = 3'd1;
  localparam logic [2:0] S_RDPG = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.req_free || stat.head_valid) begin
            state_next = S_EVAL;
          end else if (stat.store_full) begin
            cmd.full_emit = 1'b1;
          end else begin
            state_next = S_MAKE;
          end
        end
      end
      S_MAKE: begin
        cmd.make = 1'b1;
        if (stat.make_last) begin
          state_next = S_RDPG;
        end
      end
      S_RDPG: begin
        cmd.rd_page = 1'b1;
        state_next  = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (!stat.op_free && !stat.slot_bad) begin
          state_next = S_POP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* design/psfl_dp.sv */
module psfl_dp #(
  parameter int MAX_PAGES = psfl_pkg::MAX_PAGES_DEF,
  parameter int MAX_SLOTS = psfl_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [psfl_pkg::SPP_W-1:0]   cfg_wdata,
  input  psfl_pkg::req_t               req,
  input  psfl_pkg::ctrl_t              cmd,
  output psfl_pkg::stat_t              stat,
  output logic                         done,
  output psfl_pkg::rsp_t               rsp
);

  localparam int PA_W    = $clog2(MAX_PAGES);
  localparam int SA_W    = $clog2(MAX_SLOTS);
  localparam int PG_W    = PA_W + 1;
  localparam int SL_W    = SA_W + 1;
  localparam int PU_W    = $clog2(MAX_PAGES + 1);
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int SLOT_N  = MAX_PAGES * MAX_SLOTS;
  localparam int SLOT_AW = $clog2(SLOT_N);
  localparam logic [PG_W-1:0] PG_NIL = {PG_W{1'b1}};
  localparam logic [SL_W-1:0] SL_NIL = {SL_W{1'b1}};

  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [PA_W-1:0] p,
                                                   input logic [SA_W-1:0] s);
    return SLOT_AW'(p) * SLOT_AW'(MAX_SLOTS) + SLOT_AW'(s);
  endfunction

  // Control and latched request
  logic [psfl_pkg::SPP_W-1:0]  slots_per_page;
  logic [PU_W-1:0]             pages_in_use;
  logic [PG_W-1:0]             head;
  logic [PA_W-1:0]             page_q;
  logic                        op_q;
  logic [psfl_pkg::PAGE_W-1:0] pg_q;
  logic [psfl_pkg::SLOT_W-1:0] sl_q;
  logic [CNT_W-1:0]            chain_cnt;

  // Memories and their read registers
  logic [SL_W-1:0] pff_mem [MAX_PAGES];
  logic [PG_W-1:0] pnn_mem [MAX_PAGES];
  logic [SL_W-1:0] snf_mem [SLOT_N];
  logic            occ_mem [SLOT_N];
  logic [SL_W-1:0] pff_rd;
  logic [PG_W-1:0] pnn_rd;
  logic [SL_W-1:0] snf_rd;
  logic            occ_rd;

  logic [CNT_W-1:0]   eff;
  logic               head_valid;
  logic               store_full;
  logic               make_last;
  logic               slot_bad;
  logic               page_ok;
  logic               slot_ok;
  logic               free_ok;
  logic               is_free_eval;
  logic               is_alloc_eval;
  logic [PA_W-1:0]    page_ra;
  logic               page_re;
  logic               pff_we;
  logic [SL_W-1:0]    pff_wd;
  logic               pnn_we;
  logic [PG_W-1:0]    pnn_wd;
  logic [SLOT_AW-1:0] k_make;
  logic [SLOT_AW-1:0] k_free;
  logic [SLOT_AW-1:0] k_pop;
  logic [SLOT_AW-1:0] k_req;
  logic [SLOT_AW-1:0] slot_wa;
  logic               snf_we;
  logic [SL_W-1:0]    snf_wd;
  logic               occ_we;
  logic               occ_wd;
  logic [psfl_pkg::STATUS_W-1:0] free_status;

  always_comb begin
    if (slots_per_page == '0) begin
      eff = CNT_W'(1);
    end else if (32'(slots_per_page) > 32'(MAX_SLOTS)) begin
      eff = CNT_W'(MAX_SLOTS);
    end else begin
      eff = CNT_W'(slots_per_page);
    end
  end

  assign head_valid    = (head != PG_NIL) && (32'(head) < 32'(MAX_PAGES));
  assign store_full    = (pages_in_use == PU_W'(MAX_PAGES));
  assign make_last     = (chain_cnt == eff - CNT_W'(1));
  assign slot_bad      = (32'(pff_rd) >= 32'(MAX_SLOTS));
  assign page_ok       = (32'(pg_q) < 32'(pages_in_use)) && (32'(pg_q) < 32'(MAX_PAGES));
  assign slot_ok       = (32'(sl_q) < 32'(eff));
  assign free_ok       = page_ok && slot_ok && occ_rd;
  assign is_free_eval  = cmd.eval && (op_q == psfl_pkg::OP_FREE);
  assign is_alloc_eval = cmd.eval && (op_q == psfl_pkg::OP_ALLOC);

  always_comb begin
    if (!page_ok) begin
      free_status = psfl_pkg::ST_PAGE_RANGE;
    end else if (!slot_ok) begin
      free_status = psfl_pkg::ST_SLOT_RANGE;
    end else if (!occ_rd) begin
      free_status = psfl_pkg::ST_SLOT_EMPTY;
    end else begin
      free_status = psfl_pkg::ST_OK;
    end
  end

  assign stat.req_free   = (req.op == psfl_pkg::OP_FREE);
  assign stat.op_free    = (op_q == psfl_pkg::OP_FREE);
  assign stat.head_valid = head_valid;
  assign stat.store_full = store_full;
  assign stat.make_last  = make_last;
  assign stat.slot_bad   = slot_bad;

  // Addresses
  assign k_make = slot_addr(page_q, SA_W'(chain_cnt));
  assign k_free = slot_addr(page_q, SA_W'(sl_q));
  assign k_pop  = slot_addr(page_q, SA_W'(pff_rd));
  assign k_req  = slot_addr(PA_W'(req.page_index), SA_W'(req.slot_index));

  always_comb begin
    page_re = cmd.load || cmd.rd_page;
    if (cmd.load) begin
      page_ra = (req.op == psfl_pkg::OP_FREE) ? PA_W'(req.page_index) : PA_W'(head);
    end else begin
      page_ra = page_q;
    end
  end

  // Page list writes
  always_comb begin
    pff_we = 1'b0;
    pff_wd = '0;
    pnn_we = 1'b0;
    pnn_wd = PG_NIL;
    if (cmd.make && make_last) begin
      pff_we = 1'b1;
      pnn_we = 1'b1;
    end else if (is_free_eval && free_ok) begin
      pff_we = 1'b1;
      pff_wd = SL_W'(sl_q);
      pnn_we = (pff_rd == SL_NIL);
      pnn_wd = head;
    end else if (cmd.pop) begin
      pff_we = 1'b1;
      pff_wd = snf_rd;
    end
  end

  // Slot list writes
  always_comb begin
    slot_wa = k_make;
    snf_we  = 1'b0;
    snf_wd  = SL_NIL;
    occ_we  = 1'b0;
    occ_wd  = 1'b0;
    if (cmd.make) begin
      snf_we = 1'b1;
      snf_wd = make_last ? SL_NIL : SL_W'(chain_cnt + CNT_W'(1));
      occ_we = 1'b1;
    end else if (is_free_eval && free_ok) begin
      slot_wa = k_free;
      snf_we  = 1'b1;
      snf_wd  = pff_rd;
      occ_we  = 1'b1;
    end else if (is_alloc_eval && !slot_bad) begin
      slot_wa = k_pop;
      occ_we  = 1'b1;
      occ_wd  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pff_we) begin
      pff_mem[page_q] <= pff_wd;
    end
    if (pnn_we) begin
      pnn_mem[page_q] <= pnn_wd;
    end
    if (page_re) begin
      pff_rd <= pff_mem[page_ra];
      pnn_rd <= pnn_mem[page_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (snf_we) begin
      snf_mem[slot_wa] <= snf_wd;
    end
    if (is_alloc_eval) begin
      snf_rd <= snf_mem[k_pop];
    end
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[slot_wa] <= occ_wd;
    end
    if (cmd.load) begin
      occ_rd <= occ_mem[k_req];
    end
  end

  // Request latch and chain counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= req.op;
      pg_q      <= req.page_index;
      sl_q      <= req.slot_index;
      chain_cnt <= '0;
      if (req.op == psfl_pkg::OP_FREE) begin
        page_q <= PA_W'(req.page_index);
      end else if (head_valid) begin
        page_q <= PA_W'(head);
      end else begin
        page_q <= PA_W'(pages_in_use);
      end
    end else if (cmd.make) begin
      chain_cnt <= chain_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_page <= psfl_pkg::SPP_RESET;
      pages_in_use   <= '0;
      head           <= PG_NIL;
    end else begin
      if (cfg_we) begin
        slots_per_page <= cfg_wdata;
      end
      if (cmd.make && make_last) begin
        pages_in_use <= pages_in_use + PU_W'(1);
        head         <= PG_W'(page_q);
      end else if (is_alloc_eval && slot_bad) begin
        head <= pnn_rd;
      end else if (is_free_eval && free_ok && (pff_rd == SL_NIL)) begin
        head <= PG_W'(page_q);
      end else if (cmd.pop && (snf_rd == SL_NIL)) begin
        head <= pnn_rd;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.full_emit || is_free_eval || (is_alloc_eval && slot_bad) || cmd.pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rsp.status       <= psfl_pkg::ST_OK;
      rsp.granted_page <= psfl_pkg::PAGE_W'(page_q);
      rsp.granted_slot <= psfl_pkg::SLOT_W'(pff_rd);
    end else if (is_free_eval) begin
      rsp.status       <= free_status;
      rsp.granted_page <= '0;
      rsp.granted_slot <= '0;
    end else if (cmd.full_emit || is_alloc_eval) begin
      rsp.status       <= psfl_pkg::ST_FULL;
      rsp.granted_page <= '0;
      rsp.granted_slot <= '0;
    end
  end

endmodule
